// ===== rtl/s88bsm_pkg.sv =====
// s88bsm_pkg: shared types and constants of the S88 bus scan master.
// Used by the interfaces, the lane, the sensor store, the top level and the checker.
package s88bsm_pkg;

    // default geometry, handed down from the top level
    localparam int DEF_NUM_BUSES   = 4;
    localparam int DEF_MAX_SENSORS = 64;

    // register widths
    localparam int PULSE_W      = 10;
    localparam int SETTLE_W     = 10;
    localparam int GAP_W        = 20;
    localparam int CNT_W        = 7;
    localparam int NUM_CNT_REGS = 4;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 20;

    // register reset values
    localparam logic [PULSE_W-1:0]  RST_PULSE  = PULSE_W'(50);
    localparam logic [SETTLE_W-1:0] RST_SETTLE = SETTLE_W'(25);
    localparam logic [GAP_W-1:0]    RST_GAP    = GAP_W'(50000);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE      = 4'd0,
        CFG_SETTLE     = 4'd1,
        CFG_GAP        = 4'd2,
        CFG_BUS0       = 4'd3,
        CFG_BUS1       = 4'd4,
        CFG_BUS2       = 4'd5,
        CFG_BUS3       = 4'd6,
        CFG_ACTIVE_LOW = 4'd7
    } t_cfg_idx;

    // scan sequencer phases
    typedef enum logic [11:0] {
        PH_IDLE    = 12'b0000_0000_0001,
        PH_LOAD    = 12'b0000_0000_0010,
        PH_CLK_HI  = 12'b0000_0000_0100,
        PH_CLK_LO  = 12'b0000_0000_1000,
        PH_RST_HI  = 12'b0000_0001_0000,
        PH_RST_LO  = 12'b0000_0010_0000,
        PH_SETTLE  = 12'b0000_0100_0000,
        PH_RD_HI   = 12'b0000_1000_0000,
        PH_RD_LO   = 12'b0001_0000_0000,
        PH_LAST_HI = 12'b0010_0000_0000,
        PH_LAST_LO = 12'b0100_0000_0000,
        PH_GAP     = 12'b1000_0000_0000
    } t_phase;

    // per-bus result of one lane
    typedef struct packed {
        logic hit;      // bus still has a sensor at this position
        logic bit_val;  // active state seen on the data line
        logic changed;  // differs from the stored state
        logic store;    // value to write back into the store row
    } t_lane_res;

endpackage

// ===== rtl/s88bsm_if.sv =====
// s88bsm_if: valid/ready channel interfaces of the S88 bus scan master.
// Depends on s88bsm_pkg for register widths.
interface s88bsm_in_if import s88bsm_pkg::*; #(
    parameter int NUM_BUSES = DEF_NUM_BUSES
);
    logic                 valid;
    logic                 ready;
    logic                 tick;
    logic [NUM_BUSES-1:0] data_lines;

    modport source (output valid, output tick, output data_lines, input ready);
    modport sink   (input valid, input tick, input data_lines, output ready);
endinterface

interface s88bsm_out_if import s88bsm_pkg::*; #(
    parameter int NUM_BUSES   = DEF_NUM_BUSES,
    parameter int MAX_SENSORS = DEF_MAX_SENSORS
);
    localparam int IDX_W = $clog2(MAX_SENSORS);

    logic                 valid;
    logic                 ready;
    logic                 load_line;
    logic                 clock_line;
    logic                 reset_line;
    logic [NUM_BUSES-1:0] sample_valid;
    logic [IDX_W-1:0]     sample_index;
    logic [NUM_BUSES-1:0] sample_bits;
    logic [NUM_BUSES-1:0] changed_bits;
    logic                 scan_done;

    modport source (output valid, output load_line, output clock_line, output reset_line,
                    output sample_valid, output sample_index, output sample_bits,
                    output changed_bits, output scan_done, input ready);
    modport sink   (input valid, input load_line, input clock_line, input reset_line,
                    input sample_valid, input sample_index, input sample_bits,
                    input changed_bits, input scan_done, output ready);
endinterface

interface s88bsm_cfg_if import s88bsm_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/s88bsm_lane.sv =====
// s88bsm_lane: per-bus sample lane, checks the sensor count and compares
// the data line with the stored state. Depends on s88bsm_pkg.
module s88bsm_lane import s88bsm_pkg::*; #(
    parameter int MAX_SENSORS = DEF_MAX_SENSORS
) (
    input  logic                                 i_line,
    input  logic                                 i_old,
    input  logic [CNT_W-1:0]                     i_count,
    input  logic [$clog2(MAX_SENSORS+1)-1:0]     i_bit_pos,
    output t_lane_res                            o_res
);
    localparam int BP_W  = $clog2(MAX_SENSORS + 1);
    localparam int CMP_W = (BP_W > CNT_W) ? BP_W : CNT_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_SENSORS);

    logic [CMP_W-1:0] bp_ext;
    logic [CMP_W-1:0] cnt_ext;

    assign bp_ext  = CMP_W'(i_bit_pos);
    assign cnt_ext = CMP_W'(i_count);

    // count saturates at the store depth
    assign o_res.hit     = (bp_ext < cnt_ext) && (bp_ext < MAX_CMP);
    assign o_res.bit_val = i_line;
    assign o_res.changed = i_line ^ i_old;
    assign o_res.store   = o_res.hit ? i_line : i_old;
endmodule

// ===== rtl/s88bsm_store.sv =====
// s88bsm_store: sensor state memory, one row per sensor position holding all buses.
// A fill count stands in for the cleared reset state. Depends on s88bsm_pkg.
module s88bsm_store import s88bsm_pkg::*; #(
    parameter int NUM_BUSES   = DEF_NUM_BUSES,
    parameter int MAX_SENSORS = DEF_MAX_SENSORS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [$clog2(MAX_SENSORS+1)-1:0] i_bit_pos,
    input  logic [NUM_BUSES-1:0]             i_wr_data,
    input  logic [$clog2(MAX_SENSORS+1)-1:0] i_next_pos,
    output logic [NUM_BUSES-1:0]             o_old
);
    localparam int BP_W  = $clog2(MAX_SENSORS + 1);
    localparam int IDX_W = $clog2(MAX_SENSORS);

    logic [NUM_BUSES-1:0] r_mem [MAX_SENSORS];
    logic [NUM_BUSES-1:0] r_rd;
    logic [BP_W-1:0]      r_fill;
    logic [IDX_W-1:0]     rd_addr;

    // read ahead at the position the sequencer moves to
    assign rd_addr = i_rst_n ? i_next_pos[IDX_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_bit_pos[IDX_W-1:0]] <= i_wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // rows below the fill count have been written; scans write rows in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_wr_en && (i_bit_pos >= r_fill)) begin
            r_fill <= i_bit_pos + BP_W'(1);
        end
    end

    assign o_old = (i_bit_pos < r_fill) ? r_rd : '0;
endmodule

// ===== rtl/s88_bus_scan_master_unit.sv =====
// s88_bus_scan_master_unit: top level of the S88 feedback bus scan master.
// Depends on s88bsm_pkg, s88bsm_if, s88bsm_lane and s88bsm_store.
//
//   channel  | dir | transfer carries
//   ---------+-----+------------------------------------------------------
//   i_in     | in  | tick, data_lines
//   o_out    | out | load/clock/reset line levels, samples, scan_done
//   i_cfg    | in  | register index, write data (always ready)
//
// Sequencer, lanes and merge settle combinationally and the result lands in a
// single output register, so a new transfer is taken each cycle while the sink
// takes results. The read-ahead port of the sensor store keeps the old state of
// the next position ready when the sequencer gets there. Reset clears the config,
// sequencer and output valid registers and the store fill count at once, no sweep.
// A stalled result holds and blocks input only while the output register is full.
module s88_bus_scan_master_unit import s88bsm_pkg::*; #(
    parameter int NUM_BUSES   = DEF_NUM_BUSES,
    parameter int MAX_SENSORS = DEF_MAX_SENSORS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    s88bsm_in_if.sink   i_in,
    s88bsm_out_if.source o_out,
    s88bsm_cfg_if.sink  i_cfg
);
    localparam int BP_W  = $clog2(MAX_SENSORS + 1);
    localparam int IDX_W = $clog2(MAX_SENSORS);

    // configuration
    logic [PULSE_W-1:0]  r_pulse;
    logic [SETTLE_W-1:0] r_settle;
    logic [GAP_W-1:0]    r_gap;
    logic [CNT_W-1:0]    r_bus_count [NUM_CNT_REGS];
    logic                r_active_low;

    // sequencer state
    t_phase          r_phase, n_phase;
    logic [GAP_W-1:0] r_timer, n_timer;
    logic [BP_W-1:0]  r_bp, n_bp;

    // output register
    logic                 r_ov;
    logic                 r_load, r_clock, r_reset, r_done;
    logic [NUM_BUSES-1:0] r_svalid, r_sbits, r_chg;
    logic [IDX_W-1:0]     r_sidx;

    logic                 in_acc;
    logic [GAP_W-1:0]     timer_inc, len, pulse_len, settle_len, gap_len;
    logic                 sample, done, any_hit, wr_en;
    logic [NUM_BUSES-1:0] lines, old_bits, hits, bits, chg, store_row;
    t_lane_res            lane_res [NUM_BUSES];

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_ov || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse      <= RST_PULSE;
            r_settle     <= RST_SETTLE;
            r_gap        <= RST_GAP;
            r_active_low <= 1'b0;
            for (int b = 0; b < NUM_CNT_REGS; b++) begin
                r_bus_count[b] <= '0;
            end
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_PULSE:      r_pulse      <= i_cfg.data[PULSE_W-1:0];
                CFG_SETTLE:     r_settle     <= i_cfg.data[SETTLE_W-1:0];
                CFG_GAP:        r_gap        <= i_cfg.data[GAP_W-1:0];
                CFG_BUS0:       r_bus_count[0] <= i_cfg.data[CNT_W-1:0];
                CFG_BUS1:       r_bus_count[1] <= i_cfg.data[CNT_W-1:0];
                CFG_BUS2:       r_bus_count[2] <= i_cfg.data[CNT_W-1:0];
                CFG_BUS3:       r_bus_count[3] <= i_cfg.data[CNT_W-1:0];
                CFG_ACTIVE_LOW: r_active_low <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // phase lengths, zero counts as one tick
    assign pulse_len  = (r_pulse == '0)  ? GAP_W'(1) : GAP_W'(r_pulse);
    assign settle_len = (r_settle == '0) ? GAP_W'(1) : GAP_W'(r_settle);
    assign gap_len    = (r_gap == '0)    ? GAP_W'(1) : r_gap;

    assign lines = i_in.data_lines ^ {NUM_BUSES{r_active_low}};

    // sample lanes, one per bus
    for (genvar b = 0; b < NUM_BUSES; b++) begin : g_lane
        logic [CNT_W-1:0] cnt;
        if (b < NUM_CNT_REGS) begin : g_cnt
            assign cnt = r_bus_count[b];
        end else begin : g_nocnt
            assign cnt = '0;
        end

        s88bsm_lane #(.MAX_SENSORS(MAX_SENSORS)) u_lane (
            .i_line    (lines[b]),
            .i_old     (old_bits[b]),
            .i_count   (cnt),
            .i_bit_pos (r_bp),
            .o_res     (lane_res[b])
        );

        assign hits[b]      = lane_res[b].hit;
        assign bits[b]      = lane_res[b].bit_val;
        assign chg[b]       = lane_res[b].changed;
        assign store_row[b] = lane_res[b].store;
    end

    // merge lane findings
    assign any_hit = |hits;
    assign wr_en   = sample && any_hit;

    s88bsm_store #(.NUM_BUSES(NUM_BUSES), .MAX_SENSORS(MAX_SENSORS)) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_bit_pos  (r_bp),
        .i_wr_data  (store_row),
        .i_next_pos (n_bp),
        .o_old      (old_bits)
    );

    // sequencer next state
    always_comb begin
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_bp      = r_bp;
        sample    = 1'b0;
        done      = 1'b0;
        timer_inc = r_timer + GAP_W'(1);
        case (r_phase)
            PH_LOAD, PH_CLK_HI, PH_CLK_LO, PH_RST_HI,
            PH_RST_LO, PH_RD_HI, PH_LAST_HI:      len = pulse_len;
            PH_SETTLE, PH_RD_LO, PH_LAST_LO:      len = settle_len;
            PH_GAP:                               len = gap_len;
            default:                              len = GAP_W'(1);
        endcase
        if (in_acc && i_in.tick) begin
            if (timer_inc >= len) begin
                n_timer = '0;
                case (r_phase)
                    PH_LOAD:    n_phase = PH_CLK_HI;
                    PH_CLK_HI:  n_phase = PH_CLK_LO;
                    PH_CLK_LO:  n_phase = PH_RST_HI;
                    PH_RST_HI:  n_phase = PH_RST_LO;
                    PH_RST_LO:  n_phase = PH_SETTLE;
                    PH_RD_HI:   n_phase = PH_RD_LO;
                    PH_LAST_HI: n_phase = PH_LAST_LO;
                    PH_SETTLE, PH_RD_LO: begin
                        sample = 1'b1;
                        if (any_hit) begin
                            n_bp    = r_bp + BP_W'(1);
                            n_phase = PH_RD_HI;
                        end else begin
                            n_phase = PH_LAST_HI;
                        end
                    end
                    PH_LAST_LO: begin
                        done = 1'b1;
                        if (r_gap == '0) begin
                            n_bp    = '0;
                            n_phase = PH_LOAD;
                        end else begin
                            n_phase = PH_GAP;
                        end
                    end
                    default: begin
                        // idle, gap or a stray code: start a scan
                        n_bp    = '0;
                        n_phase = PH_LOAD;
                    end
                endcase
            end else begin
                n_timer = timer_inc;
            end
        end
    end

    // advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_bp    <= '0;
        end else begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_bp    <= n_bp;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (in_acc) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    // capture the result of each transfer
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_load   <= (n_phase == PH_LOAD) || (n_phase == PH_CLK_HI) ||
                        (n_phase == PH_CLK_LO) || (n_phase == PH_RST_HI) ||
                        (n_phase == PH_RST_LO);
            r_clock  <= (n_phase == PH_CLK_HI) || (n_phase == PH_RD_HI) ||
                        (n_phase == PH_LAST_HI);
            r_reset  <= (n_phase == PH_RST_HI);
            r_svalid <= sample ? hits : '0;
            r_sbits  <= sample ? (hits & bits) : '0;
            r_chg    <= sample ? (hits & chg) : '0;
            r_sidx   <= wr_en ? r_bp[IDX_W-1:0] : '0;
            r_done   <= done;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.load_line    = r_load;
    assign o_out.clock_line   = r_clock;
    assign o_out.reset_line   = r_reset;
    assign o_out.sample_valid = r_svalid;
    assign o_out.sample_index = r_sidx;
    assign o_out.sample_bits  = r_sbits;
    assign o_out.changed_bits = r_chg;
    assign o_out.scan_done    = r_done;
endmodule

// ===== rtl/s88bsm_checker.sv =====
// s88bsm_checker: port-level assertions for the S88 bus scan master, bound to the top.
// Depends on s88bsm_pkg and the top level s88_bus_scan_master_unit.
module s88bsm_checker import s88bsm_pkg::*; #(
    parameter int NUM_BUSES = DEF_NUM_BUSES
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic                 i_load,
    input logic                 i_clock,
    input logic                 i_reset,
    input logic [NUM_BUSES-1:0] i_svalid,
    input logic [NUM_BUSES-1:0] i_sbits,
    input logic [NUM_BUSES-1:0] i_chg,
    input logic                 i_done
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_out_valid) && !$past(i_out_ready)) |->
        (i_out_valid && $stable(i_svalid) && $stable(i_done) && $stable(i_load)))
        else $error("stalled result changed");

    // a sample always comes with a clock pulse outside the load window
    a_sample_clk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_svalid != '0)) |-> (i_clock && !i_load && !i_reset && !i_done))
        else $error("sample without clock pulse");

    // bits and change flags only on sampled buses
    a_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (((i_sbits | i_chg) & ~i_svalid) == '0))
        else $error("flags on unsampled bus");

    // scan end leaves the clock and reset lines low
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_done) |-> (!i_clock && !i_reset))
        else $error("scan end with clock or reset high");

    // reset pulse lies inside the load pulse
    a_rst_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_reset) |-> i_load)
        else $error("reset pulse outside load");
endmodule

bind s88_bus_scan_master_unit s88bsm_checker #(.NUM_BUSES(NUM_BUSES)) u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_load      (o_out.load_line),
    .i_clock     (o_out.clock_line),
    .i_reset     (o_out.reset_line),
    .i_svalid    (o_out.sample_valid),
    .i_sbits     (o_out.sample_bits),
    .i_chg       (o_out.changed_bits),
    .i_done      (o_out.scan_done)
);
